[rtl/chcg_pkg.sv]
// ----------------------------------------------------------------------------
// chcg_pkg
// Shared types and constants of the cubic Hermite curve generator.
// ----------------------------------------------------------------------------
package chcg_pkg;

    localparam int CoordW = 16;
    localparam int TanW   = 20;
    localparam int OutW   = 24;
    localparam int SegW   = 10;
    localparam int SmpW   = 5;

    // configuration register indexes
    localparam logic CFG_PER_PIECE = 1'b0;
    localparam logic CFG_T_STEP    = 1'b1;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [TanW-1:0]   tan_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // take the input word into the window
        logic start_seg;  // begin a segment, final or not
        logic final_seg;  // segment from the middle to the newest point
        logic first_tan;  // start tangent of the first segment is an end tangent
        logic step;       // evaluate one sample
        logic clear;      // curve ended
    } dp_cmd_t;

endpackage

[rtl/chcg_datapath.sv]
// ----------------------------------------------------------------------------
// chcg_datapath
// Point window, tangents and the sequential Horner evaluator, axes in turn.
// ----------------------------------------------------------------------------
module chcg_datapath
    import chcg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd,
    input  coord_t                 px,
    input  coord_t                 py,
    input  coord_t                 pz,
    input  logic [15:0]            t_in,
    output logic signed [OutW-1:0] qx,
    output logic signed [OutW-1:0] qy,
    output logic signed [OutW-1:0] qz,
    output logic                   done
);

    coord_t w_reg [3][3];
    tan_t   prev_reg [3];
    tan_t   s0_reg [3];
    tan_t   s1_reg [3];
    coord_t p0_reg [3];
    logic signed [CoordW:0] d_reg [3];
    logic signed [OutW-1:0] q_reg [3];
    logic [1:0] ax_reg;
    logic [1:0] ph_reg;
    logic busy_reg;
    logic signed [47:0] h_reg;
    logic signed [47:0] h_next;
    logic signed [64:0] prod;
    logic signed [TanW+4:0] ca;
    logic signed [TanW+4:0] cb;
    logic signed [47:0] addend;
    logic signed [47:0] rnd;
    logic [1:0] ax_nxt;
    logic [1:0] ax_seed;

    function automatic logic signed [TanW+4:0] coef_a(tan_t s0, tan_t s1,
                                                      logic signed [CoordW:0] d);
        return 25'(s0) + 25'(s1) - 25'(d) * 25'sd8;
    endfunction

    always_comb begin
        // cubic coefficient seeds axis 0 on a new sample, else the following axis
        ax_nxt  = (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
        ax_seed = cmd.step ? 2'd0 : ax_nxt;
        ca = coef_a(s0_reg[ax_seed], s1_reg[ax_seed], d_reg[ax_seed]);
        cb = 25'(d_reg[ax_reg]) * 25'sd12 - 25'(s0_reg[ax_reg]) * 25'sd2
           - 25'(s1_reg[ax_reg]);
        prod = h_reg * $signed({1'b0, t_in});
        case (ph_reg)
            2'd0:    addend = 48'(cb) <<< 16;
            2'd1:    addend = 48'(s0_reg[ax_reg]) <<< 16;
            default: addend = 48'(p0_reg[ax_reg]) <<< 18;
        endcase
        h_next = 48'(prod >>> 16) + addend;
        rnd = (h_next + 48'sd512) >>> 10;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                prev_reg[a] <= '0;
                for (int k = 0; k < 3; k++) w_reg[k][a] <= '0;
            end
        end else begin
            done <= busy_reg && !cmd.step && ph_reg == 2'd2 && ax_reg == 2'd2;
            if (cmd.clear) begin
                for (int a = 0; a < 3; a++) begin
                    prev_reg[a] <= '0;
                    for (int k = 0; k < 3; k++) w_reg[k][a] <= '0;
                end
            end else begin
                if (cmd.load) begin
                    w_reg[0] <= w_reg[1];
                    w_reg[1] <= w_reg[2];
                    w_reg[2][0] <= px;
                    w_reg[2][1] <= py;
                    w_reg[2][2] <= pz;
                end
                if (cmd.start_seg) begin
                    for (int a = 0; a < 3; a++) begin
                        logic signed [CoordW+1:0] dd;
                        logic signed [CoordW:0] d1;
                        logic signed [CoordW:0] d2;
                        dd = 18'(w_reg[2][a]) - 18'(w_reg[0][a]);
                        d1 = 17'(w_reg[1][a]) - 17'(w_reg[0][a]);
                        d2 = 17'(w_reg[2][a]) - 17'(w_reg[1][a]);
                        if (cmd.final_seg) begin
                            p0_reg[a] <= w_reg[1][a];
                            d_reg[a]  <= d2;
                            s0_reg[a] <= prev_reg[a];
                            s1_reg[a] <= TanW'(20'(d2) * 6 - 20'(dd));
                        end else begin
                            p0_reg[a] <= w_reg[0][a];
                            d_reg[a]  <= d1;
                            s0_reg[a] <= cmd.first_tan ? TanW'(20'(d1) * 6 - 20'(dd))
                                                       : prev_reg[a];
                            s1_reg[a] <= TanW'(20'(dd) * 2);
                            prev_reg[a] <= TanW'(20'(dd) * 2);
                        end
                    end
                end
            end
            if (cmd.step) begin
                busy_reg <= 1'b1;
                ax_reg <= 2'd0;
                ph_reg <= 2'd0;
                h_reg <= 48'(ca) <<< 16;
            end else if (busy_reg) begin
                if (ph_reg == 2'd2) begin
                    if (rnd > 48'sd8388607)       q_reg[ax_reg] <= 24'sh7fffff;
                    else if (rnd < -48'sd8388608) q_reg[ax_reg] <= -24'sh800000;
                    else                          q_reg[ax_reg] <= rnd[OutW-1:0];
                    ph_reg <= 2'd0;
                    if (ax_reg == 2'd2) begin
                        busy_reg <= 1'b0;
                    end else begin
                        ax_reg <= ax_nxt;
                        h_reg <= 48'(ca) <<< 16;
                    end
                end else begin
                    ph_reg <= ph_reg + 2'd1;
                    h_reg <= h_next;
                end
            end
        end
    end

    assign qx = q_reg[0];
    assign qy = q_reg[1];
    assign qz = q_reg[2];

endmodule

[rtl/chcg_controller.sv]
// ----------------------------------------------------------------------------
// chcg_controller
// Sequencer: point counting, segment and sample loops, output handshake.
// ----------------------------------------------------------------------------
module chcg_controller
    import chcg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_PER_PIECE = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_final,
    input  logic [5:0]       per_piece,
    input  logic [15:0]      t_step,
    output dp_cmd_t          cmd,
    output logic [15:0]      t_out,
    input  logic             dp_done,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [SegW-1:0]  seg_out,
    output logic [SmpW-1:0]  smp_out,
    output logic             last_out
);

    localparam int CntW = $clog2(MAX_SEGMENTS + 2) + 1;
    localparam logic [2:0] S_IDLE = 3'd0, S_SEG = 3'd1, S_STEP = 3'd2,
                           S_WAIT = 3'd3, S_OUT = 3'd4;

    logic [2:0] state_reg;
    logic [CntW-1:0] n_reg;
    logic fin_reg, fseg_reg;
    logic [5:0] i_reg;
    logic [5:0] cnt;
    logic [21:0] tt;
    logic [CntW-1:0] segw;
    logic [CntW-1:0] segn;

    assign cnt = (per_piece > 6'(MAX_PER_PIECE)) ? 6'(MAX_PER_PIECE) : per_piece;
    assign tt = 22'(i_reg) * 22'(t_step);
    assign t_out = (tt > 22'd65535) ? 16'hffff : tt[15:0];
    assign in_ready = (state_reg == S_IDLE);
    // an empty segment passes through S_OUT without a word
    assign out_valid = (state_reg == S_OUT) && (cnt != 6'd0);
    assign segw = fseg_reg ? n_reg - CntW'(1) : n_reg - CntW'(2);
    assign segn = (segw >= CntW'(MAX_SEGMENTS)) ? segw - CntW'(MAX_SEGMENTS) : segw;
    assign seg_out = SegW'(segn);
    assign smp_out = i_reg[SmpW-1:0];
    assign last_out = (i_reg + 6'd1 == cnt) && (fseg_reg || !fin_reg);

    always_comb begin
        cmd = '0;
        cmd.load = in_valid && in_ready;
        cmd.start_seg = (state_reg == S_SEG);
        cmd.final_seg = fseg_reg;
        cmd.first_tan = (n_reg == CntW'(2));
        cmd.step = (state_reg == S_STEP);
        // curve state returns to zero once the flagged point is done
        cmd.clear = (state_reg == S_IDLE && in_valid && in_final && n_reg < CntW'(2)) ||
                    (state_reg == S_OUT && (out_ready || cnt == 6'd0) && fin_reg &&
                     fseg_reg && !(cnt != 6'd0 && i_reg + 6'd1 < cnt));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            n_reg <= '0;
            fin_reg <= 1'b0;
            fseg_reg <= 1'b0;
            i_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: if (in_valid) begin
                    fin_reg <= in_final;
                    fseg_reg <= 1'b0;
                    if (n_reg >= CntW'(2)) state_reg <= S_SEG;
                    else if (in_final) n_reg <= '0;
                    else n_reg <= n_reg + CntW'(1);
                end
                S_SEG: begin
                    i_reg <= '0;
                    state_reg <= (cnt == 6'd0) ? S_OUT : S_STEP;
                end
                S_STEP: state_reg <= S_WAIT;
                S_WAIT: if (dp_done) state_reg <= S_OUT;
                S_OUT: if (out_ready || cnt == 6'd0) begin
                    if (cnt != 6'd0 && i_reg + 6'd1 < cnt) begin
                        i_reg <= i_reg + 6'd1;
                        state_reg <= S_STEP;
                    end else if (fin_reg && !fseg_reg) begin
                        fseg_reg <= 1'b1;
                        state_reg <= S_SEG;
                    end else begin
                        state_reg <= S_IDLE;
                        if (fin_reg) n_reg <= '0;
                        else if (n_reg + CntW'(1) >= CntW'(2 + MAX_SEGMENTS))
                            n_reg <= n_reg + CntW'(1) - CntW'(MAX_SEGMENTS);
                        else n_reg <= n_reg + CntW'(1);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> !in_ready) else $error("accepts while a sample waits");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready && cnt != 6'd0 |=> out_valid)
        else $error("sample dropped");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && cnt != 6'd0 |-> i_reg < cnt) else $error("sample index past count");
`endif

endmodule

[rtl/cubic_hermite_curve_generator.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_curve_generator
// Streams 3-D control points in and cubic Hermite curve samples out.
// ----------------------------------------------------------------------------
// Each point from the third onward yields per_piece samples (at most 32) of the
// segment two back; the flagged last point also yields the final segment. A
// sample runs through a start step, nine Horner steps on one multiplier (three
// per axis, axes in turn), a done step and the output handshake. The input is
// held off while a point's segment, and for the flagged last point the second
// segment too, is worked off.
module cubic_hermite_curve_generator
    import chcg_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024,
    parameter int MAX_PER_PIECE = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // px, py, pz
    input  logic        s_tlast,   // final_point
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // qx, qy, qz, segment, sample, zero pad
    output logic        m_tlast,   // run_end
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    logic [5:0]  per_piece_reg;
    logic [15:0] t_step_reg;
    dp_cmd_t cmd;
    logic [15:0] t;
    logic done;
    logic signed [OutW-1:0] qx, qy, qz;
    logic [SegW-1:0] seg;
    logic [SmpW-1:0] smp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_piece_reg <= 6'd8;
            t_step_reg <= 16'd8192;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_PER_PIECE) per_piece_reg <= cfg_wdata[5:0];
            else t_step_reg <= cfg_wdata;
        end
    end

    chcg_controller #(.MAX_SEGMENTS(MAX_SEGMENTS), .MAX_PER_PIECE(MAX_PER_PIECE)) u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready), .in_final(s_tlast),
        .per_piece(per_piece_reg), .t_step(t_step_reg), .cmd, .t_out(t), .dp_done(done),
        .out_valid(m_tvalid), .out_ready(m_tready), .seg_out(seg), .smp_out(smp),
        .last_out(m_tlast)
    );

    chcg_datapath u_dp (
        .aclk, .aresetn, .cmd, .px(s_tdata[15:0]), .py(s_tdata[31:16]),
        .pz(s_tdata[47:32]), .t_in(t), .qx, .qy, .qz, .done
    );

    assign m_tdata = {1'b0, smp, seg, qz, qy, qx};

endmodule

[verif/cubic_hermite_curve_generator_tb.sv]
// ----------------------------------------------------------------------------
// cubic_hermite_curve_generator_tb
// Streams control-point curves through the generator and checks every sample.
// ----------------------------------------------------------------------------
// Samples are predicted in the bench from the window, tangents and registers.
// Phases cover directed corner cases, short curves and random curves under
// several register settings, with source idling and sink stalls varied from
// phase to phase.
`timescale 1ns / 1ps

module cubic_hermite_curve_generator_tb;
    import chcg_pkg::*;

    localparam int   DRAIN_CYCLES  = 2 + 12 * 32 + 40;

    typedef struct {
        logic [47:0] pts;
        logic        fin;
    } point_word_t;

    typedef struct {
        logic [23:0] qx, qy, qz;
        logic [9:0]  seg;
        logic [4:0]  smp;
        logic        last;
    } sample_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // px, py, pz
    logic        s_tlast = 1'b0; // final_point
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // qx, qy, qz, segment, sample, zero pad
    logic        m_tlast;        // run_end
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wdata = '0;

    cubic_hermite_curve_generator dut (.*);

    point_word_t pending_points[$];
    sample_t     expected_samples[$];
    int          src_idle = 0;
    int          sink_stall = 0;
    int          errors = 0;
    int          points_sent = 0;
    int          samples_seen = 0;

    // predictor state
    longint      win[3][3];
    longint      last_tan[3];
    int unsigned pts_in_curve = 0;
    int unsigned pp_reg = 8;
    int unsigned ts_reg = 8192;

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("cubic_hermite_curve_generator verification failed");
        $finish;
    end

    function automatic logic [23:0] q8_sat(longint h);
        longint r;
        r = (h + 512) >>> 10;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r[23:0];
    endfunction

    task automatic predict_segment(int k0, int k1, longint s0[3], longint s1[3],
                                   int unsigned seg);
        int unsigned cnt;
        longint t, d, ca, cb, h;
        longint tt;
        logic [23:0] q[3];
        sample_t e;
        cnt = (pp_reg > 32) ? 32 : pp_reg;
        for (int i = 0; i < cnt; i++) begin
            tt = longint'(i) * ts_reg;
            t = (tt > 65535) ? 65535 : tt;
            for (int c = 0; c < 3; c++) begin
                d  = win[k1][c] - win[k0][c];
                ca = s0[c] + s1[c] - 8 * d;
                cb = 12 * d - 2 * s0[c] - s1[c];
                h  = ca * 65536;
                h  = ((h * t) >>> 16) + cb * 65536;
                h  = ((h * t) >>> 16) + s0[c] * 65536;
                h  = ((h * t) >>> 16) + win[k0][c] * 4 * 65536;
                q[c] = q8_sat(h);
            end
            e.qx = q[0]; e.qy = q[1]; e.qz = q[2];
            e.seg = seg[9:0];
            e.smp = i[4:0];
            e.last = 1'b0;
            expected_samples = {expected_samples, e};
        end
    endtask

    task automatic predict_point(logic [47:0] pts, logic fin);
        longint s0[3], s1[3], sl[3], dd;
        int queued_at_start;
        queued_at_start = expected_samples.size();
        for (int c = 0; c < 3; c++) begin
            win[0][c] = win[1][c];
            win[1][c] = win[2][c];
            win[2][c] = longint'($signed(pts[16*c +: 16]));
        end
        if (pts_in_curve >= 2) begin
            for (int c = 0; c < 3; c++) begin
                dd = win[2][c] - win[0][c];
                s1[c] = 2 * dd;
                s0[c] = (pts_in_curve == 2) ? 6 * (win[1][c] - win[0][c]) - dd
                                            : last_tan[c];
                sl[c] = 6 * (win[2][c] - win[1][c]) - dd;
            end
            predict_segment(0, 1, s0, s1, pts_in_curve - 2);
            last_tan = s1;
            if (fin) predict_segment(1, 2, s1, sl, pts_in_curve - 1);
        end
        if (fin) begin
            win = '{default: '{default: 0}};
            last_tan = '{default: 0};
            pts_in_curve = 0;
        end else begin
            pts_in_curve++;
            if (pts_in_curve >= 2 + 1024) pts_in_curve -= 1024;
        end
        if (expected_samples.size() > queued_at_start)
            expected_samples[$].last = 1'b1;
    endtask

    // source side, and sink ready
    always @(posedge aclk) begin
        point_word_t w;
        if (!s_tvalid || s_tready) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= src_idle) begin
                w = pending_points.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.pts;
                s_tlast  <= w.fin;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall);
    end

    // predict on accepted points, check accepted samples
    always @(posedge aclk) begin
        sample_t e;
        if (aresetn && s_tvalid && s_tready) begin
            predict_point(s_tdata, s_tlast);
            points_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            samples_seen++;
            if (expected_samples.size() == 0) begin
                $display("%t unexpected sample: actual %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_samples.pop_front();
                if (m_tdata[23:0] !== e.qx || m_tdata[47:24] !== e.qy ||
                    m_tdata[71:48] !== e.qz || m_tdata[81:72] !== e.seg ||
                    m_tdata[86:82] !== e.smp || m_tlast !== e.last) begin
                    $display("%t mismatch: expected q=%h,%h,%h seg %0d smp %0d last %b",
                             $time, e.qx, e.qy, e.qz, e.seg, e.smp, e.last);
                    $display("%t          actual   q=%h,%h,%h seg %0d smp %0d last %b",
                             $time, m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
                             m_tdata[81:72], m_tdata[86:82], m_tlast);
                    errors++;
                end
            end
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_point(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic fin);
        point_word_t w;
        w.pts = {z, y, x};
        w.fin = fin;
        pending_points = {pending_points, w};
    endtask

    task automatic add_random_curve(int len);
        for (int i = 0; i < len; i++)
            add_point(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_points.size() > 0 || s_tvalid || expected_samples.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_regs(int unsigned pp, int unsigned ts);
        write_reg(CFG_PER_PIECE, 16'(pp));
        write_reg(CFG_T_STEP, 16'(ts));
        pp_reg = pp & 6'h3f;
        ts_reg = ts & 16'hffff;
    endtask

    initial begin
        int unsigned pp_set[6] = '{8, 32, 1, 63, 0, 5};
        int unsigned ts_set[6] = '{8192, 2048, 65535, 3000, 0, 13107};
        int          idle_set[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{29, 29}};
        win = '{default: '{default: 0}};
        last_tan = '{default: 0};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: reset registers, extremes, short curves
        add_point(16'h7fff, 16'h8000, 16'h0000, 1'b0);
        add_point(16'h8000, 16'h7fff, 16'hffff, 1'b0);
        add_point(16'h7fff, 16'h8000, 16'h0001, 1'b1);
        add_point(16'h1234, 16'h8000, 16'h7fff, 1'b1);
        add_point(16'h0001, 16'h0002, 16'h0003, 1'b0);
        add_point(16'hffff, 16'hfffe, 16'hfffd, 1'b1);
        add_point(16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_point(16'h0010, 16'hfff0, 16'h0100, 1'b0);
        add_point(16'h8000, 16'h8000, 16'h8000, 1'b0);
        add_point(16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
        wait_idle();
        set_regs(63, 65535);
        add_random_curve(4);
        wait_idle();
        set_regs(32, 0);
        add_random_curve(3);
        wait_idle();
        set_regs(0, 2048);
        add_random_curve(5);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            set_regs(pp_set[ph], (ph == 5) ? $urandom_range(65535) : ts_set[ph]);
            src_idle   = idle_set[ph % 4][0];
            sink_stall = idle_set[ph % 4][1];
            for (int n = 0; n < 30; ) begin
                int len;
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 2)
                                               : $urandom_range(3, 10);
                add_random_curve(len);
                n += len;
            end
            wait_idle();
        end

        $display("points accepted %0d, samples checked %0d, over %0d register settings",
                 points_sent, samples_seen, 10);
        $display("idle mixes: none, source 64%%, sink 64%%, both 29%%");
        if (errors == 0 && expected_samples.size() == 0) begin
            $display("cubic_hermite_curve_generator verification clean");
        end else begin
            $display("cubic_hermite_curve_generator verification failed");
        end
        $finish;
    end

endmodule
